>>> src/cht_pkg.sv
`timescale 1ns / 1ps
// Package for the canonical Huffman code table: field widths, command and
// status codes, and the control/status structs between controller and datapath.
package cht_pkg;

  localparam int CMD_W  = 3;
  localparam int SYM_W  = 9;
  localparam int LEN_W  = 4;
  localparam int CODE_W = 15;
  localparam int STAT_W = 2;

  localparam int DEF_MAX_ENTRIES   = 512;
  localparam int DEF_MAX_CODE_BITS = 15;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DECODE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd3;

  // Micro-operations that the controller requests from the datapath.
  typedef struct packed {
    logic capture;
    logic clear_tbl;
    logic append;
    logic build_init;
    logic idx_clr;
    logic idx_inc;
    logic pass_inc;
    logic rd;
    logic reorder_wr;
    logic flip;
    logic assign_wr;
    logic set_built;
    logic res_ok;
    logic res_miss;
    logic res_over;
    logic res_hit;
    logic out_load;
  } dp_cmd_t;

  // Conditions that the datapath reports back.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             at_end;
    logic             pass_last;
    logic             lookup_skip;
    logic             match;
    logic             assign_fail;
  } dp_stat_t;

endpackage

>>> src/cht_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses of the code table.
// Depends on cht_pkg for the field widths.
interface cht_req_if;
  logic                       valid;
  logic                       ready;
  logic [cht_pkg::CMD_W-1:0]  command;
  logic [cht_pkg::SYM_W-1:0]  symbol_value;
  logic [cht_pkg::LEN_W-1:0]  code_length;
  logic [cht_pkg::CODE_W-1:0] code_word;

  modport source (output valid, command, symbol_value, code_length, code_word,
                  input ready);
  modport sink (input valid, command, symbol_value, code_length, code_word,
                output ready);
endinterface

interface cht_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [cht_pkg::STAT_W-1:0] status;
  logic [cht_pkg::SYM_W-1:0]  found_value;
  logic [cht_pkg::CODE_W-1:0] found_code;
  logic [cht_pkg::LEN_W-1:0]  found_length;

  modport source (output valid, status, found_value, found_code, found_length,
                  input ready);
  modport sink (input valid, status, found_value, found_code, found_length,
                output ready);
endinterface

>>> src/cht_dp.sv
`timescale 1ns / 1ps
// Datapath of the code table: two entry banks, counters, code assignment,
// lookup compare and result registers. Depends on cht_pkg.
module cht_dp #(
  parameter int MAX_ENTRIES   = cht_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_CODE_BITS = cht_pkg::DEF_MAX_CODE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cht_pkg::CMD_W-1:0]  command_i,
  input  logic [cht_pkg::SYM_W-1:0]  symbol_value_i,
  input  logic [cht_pkg::LEN_W-1:0]  code_length_i,
  input  logic [cht_pkg::CODE_W-1:0] code_word_i,
  input  cht_pkg::dp_cmd_t           cmd_i,
  output cht_pkg::dp_stat_t          stat_o,
  output logic [cht_pkg::STAT_W-1:0] status_o,
  output logic [cht_pkg::SYM_W-1:0]  found_value_o,
  output logic [cht_pkg::CODE_W-1:0] found_code_o,
  output logic [cht_pkg::LEN_W-1:0]  found_length_o
);
  import cht_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef enum logic [1:0] {PH_NONE, PH_BUILT, PH_FAILED} phase_e;

  entry_t bank0_q [MAX_ENTRIES];
  entry_t bank1_q [MAX_ENTRIES];
  entry_t rd_q;

  logic [CMD_W-1:0]  cmd_q;
  logic [SYM_W-1:0]  sym_q;
  logic [LEN_W-1:0]  len_q;
  logic [CODE_W-1:0] word_q;

  logic [CW-1:0]     total_q, total_d;
  phase_e            phase_q, phase_d;
  logic              sel_q, sel_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     n_q, n_d;
  logic [LEN_W-1:0]  pass_q, pass_d;
  logic [LEN_W-1:0]  cur_q, cur_d;
  logic [CODE_W:0]   next_q, next_d;

  logic [STAT_W-1:0] res_st_q;
  logic [SYM_W-1:0]  res_fv_q;
  logic [CODE_W-1:0] res_fc_q;
  logic [LEN_W-1:0]  res_fl_q;

  logic              full;
  logic              wr_en, wr_bank;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;

  logic              up, zero_case, over_len, assign_fail;
  logic [CODE_W:0]   base;
  logic [LEN_W-1:0]  bitpos;

  assign full = (total_q == CW'(MAX_ENTRIES));

  // Code assignment for the entry in rd_q, in ascending length order.
  always_comb begin
    up        = rd_q.len > cur_q;
    zero_case = !up && (cur_q == '0);
    base      = up ? (next_q << (rd_q.len - cur_q)) : next_q;
    bitpos    = up ? rd_q.len : cur_q;
    over_len  = int'(rd_q.len) > MAX_CODE_BITS;
    assign_fail = over_len || (!zero_case && base[bitpos]);
    cur_d     = up ? rd_q.len : cur_q;
    next_d    = zero_case ? next_q : base + 1'b1;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_bank = sel_q;
    wr_addr = idx_q[AW-1:0];
    wr_data = rd_q;
    if (cmd_i.append && !full) begin
      wr_en   = 1'b1;
      wr_addr = total_q[AW-1:0];
      wr_data = '{len: len_q, sym: sym_q, code: '0};
    end else if (cmd_i.reorder_wr && (rd_q.len == pass_q)) begin
      wr_en   = 1'b1;
      wr_bank = !sel_q;
      wr_addr = n_q[AW-1:0];
    end else if (cmd_i.assign_wr) begin
      wr_en        = 1'b1;
      wr_data.code = zero_case ? '0 : base[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_bank) begin
      bank0_q[wr_addr] <= wr_data;
    end
    if (wr_en && wr_bank) begin
      bank1_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_q <= sel_q ? bank1_q[idx_q[AW-1:0]] : bank0_q[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    total_d = total_q;
    phase_d = phase_q;
    sel_d   = sel_q;
    idx_d   = idx_q;
    n_d     = n_q;
    pass_d  = pass_q;
    if (cmd_i.clear_tbl) begin
      total_d = '0;
      phase_d = PH_NONE;
    end
    if (cmd_i.append && !full) begin
      total_d = total_q + 1'b1;
      phase_d = PH_NONE;
    end
    if (cmd_i.build_init) begin
      n_d    = '0;
      pass_d = '0;
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.pass_inc) begin
      pass_d = pass_q + 1'b1;
    end
    if (cmd_i.reorder_wr && (rd_q.len == pass_q)) begin
      n_d = n_q + 1'b1;
    end
    if (cmd_i.flip) begin
      sel_d = !sel_q;
    end
    if (cmd_i.set_built) begin
      phase_d = PH_BUILT;
    end
    if (cmd_i.res_over) begin
      phase_d = PH_FAILED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      phase_q <= PH_NONE;
      sel_q   <= 1'b0;
      idx_q   <= '0;
      n_q     <= '0;
      pass_q  <= '0;
    end else begin
      total_q <= total_d;
      phase_q <= phase_d;
      sel_q   <= sel_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      pass_q  <= pass_d;
    end
  end

  // Payload registers: captured request, code walk, results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= command_i;
      sym_q  <= symbol_value_i;
      len_q  <= code_length_i;
      word_q <= code_word_i;
    end
    if (cmd_i.flip) begin
      cur_q  <= '0;
      next_q <= '0;
    end else if (cmd_i.assign_wr) begin
      cur_q  <= cur_d;
      next_q <= next_d;
    end
    if (cmd_i.res_ok || (cmd_i.append && !full)) begin
      res_st_q <= ST_OK;
      res_fv_q <= '0;
      res_fc_q <= '0;
      res_fl_q <= '0;
    end else if (cmd_i.append || cmd_i.res_miss || cmd_i.res_over) begin
      res_st_q <= cmd_i.append ? ST_FULL : (cmd_i.res_over ? ST_OVER : ST_MISS);
      res_fv_q <= '0;
      res_fc_q <= '0;
      res_fl_q <= '0;
    end else if (cmd_i.res_hit) begin
      res_st_q <= ST_OK;
      res_fv_q <= (cmd_q == CMD_DECODE) ? rd_q.sym : '0;
      res_fc_q <= (cmd_q == CMD_DECODE) ? '0 : rd_q.code;
      res_fl_q <= (cmd_q == CMD_DECODE) ? '0 : rd_q.len;
    end
    if (cmd_i.out_load) begin
      status_o       <= res_st_q;
      found_value_o  <= res_fv_q;
      found_code_o   <= res_fc_q;
      found_length_o <= res_fl_q;
    end
  end

  assign stat_o.cmd         = cmd_q;
  assign stat_o.at_end      = (idx_q == total_q);
  assign stat_o.pass_last   = (pass_q == '1);
  assign stat_o.lookup_skip = (phase_q == PH_FAILED) ||
                              ((cmd_q == CMD_DECODE) && (len_q == '0));
  assign stat_o.match       = (cmd_q == CMD_DECODE) ?
                              ((rd_q.len == len_q) && (rd_q.code == word_q)) :
                              (rd_q.sym == sym_q);
  assign stat_o.assign_fail = assign_fail;

`ifndef NO_ASSERTIONS
  a_total_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MAX_ENTRIES)) else $error("entry count beyond capacity");
  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.append && full) |=> $stable(total_q))
    else $error("append to a full table changed the count");
  a_no_bad_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.assign_wr |-> !assign_fail)
    else $error("code written for an oversubscribed entry");
  a_reorder_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flip |-> (n_q == total_q))
    else $error("reorder lost or duplicated entries");
`endif

endmodule

>>> src/cht_ctrl.sv
`timescale 1ns / 1ps
// Controller of the code table: sequences clear, append, build and lookups
// over the datapath and owns the handshakes. Depends on cht_pkg.
module cht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cht_pkg::dp_cmd_t   cmd_o,
  input  cht_pkg::dp_stat_t  stat_i
);
  import cht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_R_READ, S_R_EVAL, S_A_READ, S_A_EVAL,
    S_L_READ, S_L_EVAL, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.cmd)
          CMD_CLEAR: begin
            cmd_o.clear_tbl = 1'b1;
            cmd_o.res_ok    = 1'b1;
            state_d         = S_FIN;
          end
          CMD_APPEND: begin
            cmd_o.append = 1'b1;
            state_d      = S_FIN;
          end
          CMD_BUILD: begin
            cmd_o.build_init = 1'b1;
            cmd_o.idx_clr    = 1'b1;
            state_d          = S_R_READ;
          end
          CMD_DECODE, CMD_ENCODE: begin
            if (stat_i.lookup_skip) begin
              cmd_o.res_miss = 1'b1;
              state_d        = S_FIN;
            end else begin
              cmd_o.idx_clr = 1'b1;
              state_d       = S_L_READ;
            end
          end
          default: begin
            cmd_o.res_ok = 1'b1;
            state_d      = S_FIN;
          end
        endcase
      end
      S_R_READ: begin
        if (stat_i.at_end) begin
          cmd_o.idx_clr = 1'b1;
          if (stat_i.pass_last) begin
            cmd_o.flip = 1'b1;
            state_d    = S_A_READ;
          end else begin
            cmd_o.pass_inc = 1'b1;
          end
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_R_EVAL;
        end
      end
      S_R_EVAL: begin
        cmd_o.reorder_wr = 1'b1;
        cmd_o.idx_inc    = 1'b1;
        state_d          = S_R_READ;
      end
      S_A_READ: begin
        if (stat_i.at_end) begin
          cmd_o.set_built = 1'b1;
          cmd_o.res_ok    = 1'b1;
          state_d         = S_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        if (stat_i.assign_fail) begin
          cmd_o.res_over = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.assign_wr = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = S_A_READ;
        end
      end
      S_L_READ: begin
        if (stat_i.at_end) begin
          cmd_o.res_miss = 1'b1;
          state_d        = S_FIN;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_L_EVAL;
        end
      end
      S_L_EVAL: begin
        if (stat_i.match) begin
          cmd_o.res_hit = 1'b1;
          state_d       = S_FIN;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_L_READ;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.out_load)
    else $error("result overwritten before its transfer");
  a_accept_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_DISPATCH))
    else $error("accepted request not dispatched");
  a_single_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.res_ok, cmd_o.res_miss, cmd_o.res_over, cmd_o.res_hit}) <= 1)
    else $error("conflicting result selects");
`endif

endmodule

>>> src/canonical_huffman_table.sv
`timescale 1ns / 1ps
// Top level of the canonical Huffman code table. Uses cht_pkg, cht_req_if,
// cht_rsp_if, cht_ctrl and cht_dp.
//
// The block keeps up to MAX_ENTRIES (symbol, length) entries in two banks of
// on-chip memory and handles one request at a time; every request gives
// exactly one response transfer. A build reorders the table by length with
// sixteen passes over the entries, copying from the active bank to the spare
// one, then walks the reordered bank once more to hand out canonical codes;
// each entry is read and then evaluated in a separate step. A failed build
// stops at the first entry that is oversubscribed or longer than MAX_CODE_BITS.
// Decode and encode lookups scan the table in order and stop at the first
// match; a lookup after a failed build, or a decode with length zero, misses
// without a scan. A finished response sits in an output register until it is
// taken; the next request is accepted as soon as the previous response has
// been written there.
module canonical_huffman_table #(
  parameter int MAX_ENTRIES   = cht_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_CODE_BITS = cht_pkg::DEF_MAX_CODE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cht_req_if.sink   req_i,
  cht_rsp_if.source rsp_o
);
  import cht_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencing of each request over the datapath.
  cht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .cmd_o      (dp_cmd),
    .stat_i     (dp_stat)
  );

  // Entry storage, code assignment and lookup compare.
  cht_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (req_i.command),
    .symbol_value_i(req_i.symbol_value),
    .code_length_i (req_i.code_length),
    .code_word_i   (req_i.code_word),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .status_o      (rsp_o.status),
    .found_value_o (rsp_o.found_value),
    .found_code_o  (rsp_o.found_code),
    .found_length_o(rsp_o.found_length)
  );

endmodule
